[rtl/assert_macros.svh]
// Assertion macros shared by the smoother RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

[rtl/tls_pkg.sv]
// Package of shared constants and types for the three-tap line smoother.
`timescale 1ns / 1ps

package tls_pkg;

   localparam int PIXEL_BITS_DEF       = 16;
   localparam int WEIGHT_FRAC_BITS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF      = 4;

   // Weight registers are fixed 16-bit unsigned fractions.
   localparam int WEIGHT_BITS = 16;
   localparam logic [WEIGHT_BITS-1:0] SIDE_WEIGHT_RESET   = 16'd784;
   localparam logic [WEIGHT_BITS-1:0] CENTER_WEIGHT_RESET = 16'd41832;

   localparam int CSR_ADDR_BITS = 2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_SIDE_WEIGHT   = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CENTER_WEIGHT = 2'd1;

   // Which of the two results a queued window produces.
   // emit_inner: result for the pending pixel (left, center, right).
   // emit_edge : result for the line's last pixel (center, right, right).
   typedef struct packed {
      logic emit_inner;
      logic emit_edge;
   } job_flags_type;

   localparam int JOB_FLAG_BITS = $bits(job_flags_type);

endpackage

[rtl/tls_front.sv]
// Front end: tracks the line window and queues a job for each accepted pixel that completes a window or ends a line.
`timescale 1ns / 1ps

module tls_front #(
   parameter int PIXEL_BITS = tls_pkg::PIXEL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [PIXEL_BITS-1:0] in_pixel,
   input  logic                  in_last,
   input  logic                  queue_full,
   output logic                  push,
   output logic [PIXEL_BITS-1:0] job_left,
   output logic [PIXEL_BITS-1:0] job_center,
   output logic [PIXEL_BITS-1:0] job_right,
   output tls_pkg::job_flags_type job_flags
);
   import tls_pkg::*;

   logic [PIXEL_BITS-1:0] older_ff, older_in;
   logic [PIXEL_BITS-1:0] pend_ff, pend_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic                  pend_first_ff, pend_first_in;
   logic                  accept;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign push     = accept && (pend_valid_ff || in_last);

   always_comb begin
      older_in      = older_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      pend_first_in = pend_first_ff;
      job_left      = in_pixel;
      job_center    = in_pixel;
      job_right     = in_pixel;
      job_flags     = '{emit_inner: 1'b0, emit_edge: 1'b1};
      if (pend_valid_ff) begin
         job_left   = pend_first_ff ? pend_ff : older_ff;
         job_center = pend_ff;
         job_flags  = '{emit_inner: 1'b1, emit_edge: in_last};
      end
      if (accept) begin
         if (in_last) begin
            // close the line, drop the window
            older_in      = '0;
            pend_in       = '0;
            pend_valid_in = 1'b0;
            pend_first_in = 1'b0;
         end else if (!pend_valid_ff) begin
            older_in      = in_pixel;
            pend_in       = in_pixel;
            pend_valid_in = 1'b1;
            pend_first_in = 1'b1;
         end else begin
            older_in      = pend_ff;
            pend_in       = in_pixel;
            pend_first_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff      <= '0;
         pend_ff       <= '0;
         pend_valid_ff <= 1'b0;
         pend_first_ff <= 1'b0;
      end else begin
         older_ff      <= older_in;
         pend_ff       <= pend_in;
         pend_valid_ff <= pend_valid_in;
         pend_first_ff <= pend_first_in;
      end
   end

endmodule

[rtl/tls_queue.sv]
// Short job queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps

module tls_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = tls_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);
   import tls_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    data_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign rd_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         data_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`include "assert_macros.svh"

   `ASSERT_IMPLY(a_no_write_when_full, clock, reset, wr_en, !full)
   `ASSERT_IMPLY(a_no_read_when_empty, clock, reset, rd_en, !empty)
   `ASSERT_NEXT(a_write_fills, clock, reset, wr_en && !rd_en && !reset, !empty)

endmodule

[rtl/tls_back.sv]
// Back end: issues queued jobs and runs the weighted sum, rounding and clamp.
`timescale 1ns / 1ps

module tls_back #(
   parameter int PIXEL_BITS       = tls_pkg::PIXEL_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = tls_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [tls_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [tls_pkg::WEIGHT_BITS-1:0]     csr_wdata,
   input  logic                                queue_empty,
   input  logic [PIXEL_BITS-1:0]               head_left,
   input  logic [PIXEL_BITS-1:0]               head_center,
   input  logic [PIXEL_BITS-1:0]               head_right,
   input  tls_pkg::job_flags_type              head_flags,
   output logic                                pop,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [PIXEL_BITS-1:0]               out_pixel,
   output logic                                out_last
);
   import tls_pkg::*;

   localparam int SUM_BITS  = PIXEL_BITS + 1;
   localparam int SIDE_BITS = SUM_BITS + WEIGHT_BITS;
   localparam int CTR_BITS  = PIXEL_BITS + WEIGHT_BITS;
   localparam int ACC_BITS  = PIXEL_BITS + WEIGHT_BITS + 2;
   localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (WEIGHT_FRAC_BITS - 1);

   logic [WEIGHT_BITS-1:0] side_w_ff, side_w_in;
   logic [WEIGHT_BITS-1:0] center_w_ff, center_w_in;

   logic                  phase_ff, phase_in;
   logic                  pipe_en;
   logic                  issue;
   logic                  job_inner;
   logic [PIXEL_BITS-1:0] op_left, op_center;

   logic                  s1_valid_ff, s1_valid_in;
   logic [SUM_BITS-1:0]   s1_sum_ff, s1_sum_in;
   logic [PIXEL_BITS-1:0] s1_ctr_ff, s1_ctr_in;
   logic                  s1_last_ff, s1_last_in;

   logic                  s2_valid_ff, s2_valid_in;
   logic [SIDE_BITS-1:0]  s2_side_ff, s2_side_in;
   logic [CTR_BITS-1:0]   s2_ctr_ff, s2_ctr_in;
   logic                  s2_last_ff, s2_last_in;

   logic                  out_valid_ff, out_valid_in;
   logic [PIXEL_BITS-1:0] out_pixel_ff, out_pixel_in;
   logic                  out_last_ff, out_last_in;

   logic [ACC_BITS-1:0]   acc;
   logic [ACC_BITS-1:0]   scaled;

   // Weight registers
   always_comb begin
      side_w_in   = side_w_ff;
      center_w_in = center_w_ff;
      if (csr_wen) begin
         case (csr_addr)
            REG_SIDE_WEIGHT:   side_w_in   = csr_wdata;
            REG_CENTER_WEIGHT: center_w_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Whole pipe advances unless the output beat is stalled.
   assign pipe_en   = !out_valid_ff || out_ready;
   assign issue     = pipe_en && !queue_empty;
   assign job_inner = head_flags.emit_inner && !phase_ff;
   assign pop       = issue && !(job_inner && head_flags.emit_edge);

   // Edge result takes (center, right, right) of the queued window.
   assign op_left   = job_inner ? head_left : head_center;
   assign op_center = job_inner ? head_center : head_right;

   always_comb begin
      phase_in = phase_ff;
      if (issue) begin
         phase_in = job_inner && head_flags.emit_edge;
      end
   end

   assign s1_valid_in = issue;
   assign s1_sum_in   = {1'b0, op_left} + {1'b0, head_right};
   assign s1_ctr_in   = op_center;
   assign s1_last_in  = !job_inner;

   assign s2_valid_in = s1_valid_ff;
   assign s2_side_in  = s1_sum_ff * side_w_ff;
   assign s2_ctr_in   = s1_ctr_ff * center_w_ff;
   assign s2_last_in  = s1_last_ff;

   assign acc    = ACC_BITS'(s2_side_ff) + ACC_BITS'(s2_ctr_ff) + ROUND_HALF;
   assign scaled = acc >> WEIGHT_FRAC_BITS;

   assign out_valid_in = s2_valid_ff;
   assign out_pixel_in = (|scaled[ACC_BITS-1:PIXEL_BITS]) ? '1 : scaled[PIXEL_BITS-1:0];
   assign out_last_in  = s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_w_ff    <= SIDE_WEIGHT_RESET;
         center_w_ff  <= CENTER_WEIGHT_RESET;
         phase_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         side_w_ff   <= side_w_in;
         center_w_ff <= center_w_in;
         phase_ff    <= phase_in;
         if (pipe_en) begin
            s1_valid_ff  <= s1_valid_in;
            s2_valid_ff  <= s2_valid_in;
            out_valid_ff <= out_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_sum_ff    <= s1_sum_in;
         s1_ctr_ff    <= s1_ctr_in;
         s1_last_ff   <= s1_last_in;
         s2_side_ff   <= s2_side_in;
         s2_ctr_ff    <= s2_ctr_in;
         s2_last_ff   <= s2_last_in;
         out_pixel_ff <= out_pixel_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pixel = out_pixel_ff;
   assign out_last  = out_last_ff;

`include "assert_macros.svh"

   `ASSERT_IMPLY(a_pop_only_on_issue, clock, reset, pop, issue)
   `ASSERT_IMPLY(a_phase_needs_head, clock, reset, phase_ff, !queue_empty)
   `ASSERT_IMPLY(a_phase_means_edge, clock, reset, phase_ff, head_flags.emit_edge)

endmodule

[rtl/three_tap_line_smoother_core.sv]
// Top level of the three-tap line smoother: front end, job queue, back end.
//
//   channel  | direction | beat                        | handshake
//   ---------+-----------+-----------------------------+------------------
//   req_     | in        | tdata pixel, tlast line end | tvalid & tready
//   rsp_     | out       | tdata pixel, tlast line done| tvalid & tready
//   csr_     | in        | index, weight value         | csr_wen
//
// One pixel is accepted per clock while the job queue has room; a stalled output beat
// holds the back-end pipe and the queue keeps taking pixels until it is full.
// A line-ending pixel yields two results (one for a single-pixel line), issued in
// consecutive cycles unless the output stalls; every other pixel yields at most one.
// rsp_tvalid rises once a job, written into the queue at the accepting edge, has passed
// the registered operand, multiplier and sum/round/clamp stages in turn.
// Reset clears the line window, the queue and the pipe, and loads default weights.
`timescale 1ns / 1ps

module three_tap_line_smoother_core #(
   parameter int PIXEL_BITS       = tls_pkg::PIXEL_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = tls_pkg::WEIGHT_FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH      = tls_pkg::QUEUE_DEPTH_DEF,
   parameter int DATA_BITS        = ((PIXEL_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [DATA_BITS-1:0]              req_tdata,  // pixel
   input  logic                              req_tlast,  // line_end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [DATA_BITS-1:0]              rsp_tdata,  // smoothed_pixel
   output logic                              rsp_tlast,  // line_done
   input  logic                              csr_wen,
   input  logic [tls_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [tls_pkg::WEIGHT_BITS-1:0]   csr_wdata
);
   import tls_pkg::*;

   localparam int JOB_BITS = 3 * PIXEL_BITS + JOB_FLAG_BITS;

   logic                  push;
   logic                  pop;
   logic                  q_full;
   logic                  q_empty;
   logic [PIXEL_BITS-1:0] job_left, job_center, job_right;
   job_flags_type         job_flags;
   logic [JOB_BITS-1:0]   q_wr_data, q_rd_data;
   logic [PIXEL_BITS-1:0] head_left, head_center, head_right;
   job_flags_type         head_flags;
   logic [PIXEL_BITS-1:0] out_pixel;

   tls_front #(
      .PIXEL_BITS(PIXEL_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_pixel   (req_tdata[PIXEL_BITS-1:0]),
      .in_last    (req_tlast),
      .queue_full (q_full),
      .push       (push),
      .job_left   (job_left),
      .job_center (job_center),
      .job_right  (job_right),
      .job_flags  (job_flags)
   );

   assign q_wr_data = {job_flags, job_right, job_center, job_left};

   tls_queue #(
      .WIDTH(JOB_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (q_wr_data),
      .rd_en   (pop),
      .rd_data (q_rd_data),
      .full    (q_full),
      .empty   (q_empty)
   );

   assign head_left   = q_rd_data[PIXEL_BITS-1:0];
   assign head_center = q_rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
   assign head_right  = q_rd_data[3*PIXEL_BITS-1:2*PIXEL_BITS];
   assign head_flags  = job_flags_type'(q_rd_data[JOB_BITS-1:3*PIXEL_BITS]);

   tls_back #(
      .PIXEL_BITS       (PIXEL_BITS),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .queue_empty (q_empty),
      .head_left   (head_left),
      .head_center (head_center),
      .head_right  (head_right),
      .head_flags  (head_flags),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_pixel   (out_pixel),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = DATA_BITS'(out_pixel);

endmodule
